// File: design/pd_line_follow_steering_defines.svh
// ----------------------------------------------------------------------------
// pd_line_follow_steering_defines.svh
// Assertion macros used by the steering controller RTL.
// ----------------------------------------------------------------------------
`ifndef PD_LINE_FOLLOW_STEERING_DEFINES_SVH
`define PD_LINE_FOLLOW_STEERING_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PDLF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define PDLF_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pdlf_pkg.sv
// ----------------------------------------------------------------------------
// pdlf_pkg
// Types and constants of the PD line follower steering controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdlf_pkg;

	typedef enum logic [2:0] {
		MODE_INIT        = 3'd0,
		MODE_CALIBRATING = 3'd1,
		MODE_READY       = 3'd2,
		MODE_FOLLOWING   = 3'd3,
		MODE_FORCED_STOP = 3'd4,
		MODE_REACHED_END = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ACT_TICK      = 2'd0,
		ACT_START     = 2'd1,
		ACT_STOP      = 2'd2,
		ACT_CALIBRATE = 2'd3
	} action_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SPD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CEIL_SPD   = 3'd4;
	localparam int CFG_DATA_W = 12;

	localparam int GAIN_W  = 12;
	localparam int BASE_W  = 9;
	localparam int SPEED_W = 10;
	localparam int POS_W   = 12;
	localparam int ERR_W   = 12;

	localparam logic [POS_W-1:0] POS_CENTER = 12'd2000;
	localparam logic [POS_W-1:0] POS_MAX    = 12'd4000;

	localparam logic [GAIN_W-1:0]         RST_PROP_GAIN  = 12'd64;
	localparam logic [GAIN_W-1:0]         RST_DERIV_GAIN = 12'd256;
	localparam logic [BASE_W-1:0]         RST_CRUISE_SPD = 9'd200;
	localparam logic signed [SPEED_W-1:0] RST_FLOOR_SPD  = 10'sd0;
	localparam logic [BASE_W-1:0]         RST_CEIL_SPD   = 9'd400;

	typedef struct packed {
		logic [GAIN_W-1:0]         prop_gain;
		logic [GAIN_W-1:0]         deriv_gain;
		logic [BASE_W-1:0]         cruise_spd;
		logic signed [SPEED_W-1:0] floor_spd;
		logic [BASE_W-1:0]         ceil_spd;
	} pdlf_cfg_t;

endpackage

// File: design/pdlf_pd_calc.sv
// ----------------------------------------------------------------------------
// pdlf_pd_calc
// Proportional-derivative steering term and clamped left/right speeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdlf_pd_calc import pdlf_pkg::*; (
	input  pdlf_cfg_t                 cfg,
	input  logic [POS_W-1:0]          line_position,
	input  logic signed [ERR_W-1:0]   prev_error,
	output logic signed [ERR_W-1:0]   error,
	output logic signed [SPEED_W-1:0] left_speed,
	output logic signed [SPEED_W-1:0] right_speed
);

	localparam int DIFF_W = ERR_W + 1;
	localparam int PP_W   = 25;
	localparam int PD_W   = 26;
	localparam int SUM_W  = 20;

	logic [POS_W-1:0]        pos_sat;
	logic signed [POS_W:0]   err_wide;
	logic signed [DIFF_W-1:0] err_diff;
	logic signed [PP_W-1:0]  prod_p;
	logic signed [PD_W-1:0]  prod_d;
	logic signed [PP_W-1:0]  rnd_p;
	logic signed [PD_W-1:0]  rnd_d;
	logic signed [SUM_W-1:0] steer;
	logic signed [SUM_W-1:0] base_ext;

	function automatic logic signed [SPEED_W-1:0] clamp_speed(
		input logic signed [SUM_W-1:0]   v,
		input logic signed [SPEED_W-1:0] lo,
		input logic [BASE_W-1:0]         hi
	);
		logic signed [SUM_W-1:0] lo_ext;
		logic signed [SUM_W-1:0] hi_ext;
		lo_ext = SUM_W'(lo);
		hi_ext = $signed(SUM_W'(hi));
		if (v < lo_ext) begin
			return lo;
		end else if (v > hi_ext) begin
			return $signed({1'b0, hi});
		end
		return v[SPEED_W-1:0];
	endfunction

	always_comb begin
		pos_sat  = (line_position > POS_MAX) ? POS_MAX : line_position;
		err_wide = $signed({1'b0, pos_sat}) - $signed({1'b0, POS_CENTER});
		error    = err_wide[ERR_W-1:0];
		err_diff = DIFF_W'(error) - DIFF_W'(prev_error);

		prod_p = PP_W'(error) * $signed(PP_W'(cfg.prop_gain));
		prod_d = PD_W'(err_diff) * $signed(PD_W'(cfg.deriv_gain));

		// Adding 255 before the arithmetic shift makes negative quotients
		// round toward zero.
		rnd_p = prod_p + (prod_p[PP_W-1] ? PP_W'(255) : PP_W'(0));
		rnd_d = prod_d + (prod_d[PD_W-1] ? PD_W'(255) : PD_W'(0));

		steer    = SUM_W'(rnd_p >>> 8) + SUM_W'(rnd_d >>> 8);
		base_ext = $signed(SUM_W'(cfg.cruise_spd));

		left_speed  = clamp_speed(base_ext + steer, cfg.floor_spd, cfg.ceil_spd);
		right_speed = clamp_speed(base_ext - steer, cfg.floor_spd, cfg.ceil_spd);
	end

endmodule

// File: design/pd_line_follow_steering.sv
// ----------------------------------------------------------------------------
// pd_line_follow_steering: PD line follower steering controller.
// Pipeline: an accepted request is registered in the input register and its result
// in the result register, where it is held while result_stall is high.
// Throughput: one request per cycle while the result channel is not stalled.
// Reset clears the mode to init, the stored error to zero and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pd_line_follow_steering_defines.svh"

module pd_line_follow_steering import pdlf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [1:0]                action,
	input  logic                      line_found,
	input  logic [POS_W-1:0]          line_position,
	// result channel
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic                      motor_update,
	output logic signed [SPEED_W-1:0] left_speed,
	output logic signed [SPEED_W-1:0] right_speed,
	output logic                      calibrate_pulse,
	output logic [2:0]                mode,
	// configuration channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	pdlf_cfg_t cfg_q;

	logic                    valid_s1;
	action_t                 action_s1;
	logic                    found_s1;
	logic [POS_W-1:0]        pos_s1;

	logic                      valid_s2;
	logic                      update_s2;
	logic signed [SPEED_W-1:0] left_s2;
	logic signed [SPEED_W-1:0] right_s2;
	logic                      pulse_s2;
	mode_t                     mode_s2;

	mode_t                   mode_q;
	mode_t                   mode_d;
	logic signed [ERR_W-1:0] prev_err_q;

	logic                      upd_d;
	logic                      pulse_d;
	logic                      take_pd;
	logic signed [ERR_W-1:0]   err_new;
	logic signed [SPEED_W-1:0] pd_left;
	logic signed [SPEED_W-1:0] pd_right;

	logic s2_free;
	logic advance;
	logic accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= RST_PROP_GAIN;
			cfg_q.deriv_gain <= RST_DERIV_GAIN;
			cfg_q.cruise_spd <= RST_CRUISE_SPD;
			cfg_q.floor_spd  <= RST_FLOOR_SPD;
			cfg_q.ceil_spd   <= RST_CEIL_SPD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data[GAIN_W-1:0];
				CFG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data[GAIN_W-1:0];
				CFG_CRUISE_SPD: cfg_q.cruise_spd <= cfg_data[BASE_W-1:0];
				CFG_FLOOR_SPD:  cfg_q.floor_spd  <= $signed(cfg_data[SPEED_W-1:0]);
				CFG_CEIL_SPD:   cfg_q.ceil_spd   <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// The input register holds while the result register is full and stalled.
	assign s2_free    = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action_t'(action);
			found_s1  <= line_found;
			pos_s1    <= line_position;
		end
	end

	pdlf_pd_calc u_pd_calc (
		.cfg           (cfg_q),
		.line_position (pos_s1),
		.prev_error    (prev_err_q),
		.error         (err_new),
		.left_speed    (pd_left),
		.right_speed   (pd_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_INIT;
			prev_err_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			if (take_pd) begin
				prev_err_q <= err_new;
			end
		end
	end

	always_comb begin
		mode_d  = mode_q;
		upd_d   = 1'b0;
		pulse_d = 1'b0;
		take_pd = 1'b0;
		unique case (action_s1)
			ACT_TICK: begin
				unique case (mode_q) inside
					MODE_CALIBRATING: begin
						pulse_d = 1'b1;
						mode_d  = MODE_READY;
					end
					MODE_FOLLOWING: begin
						upd_d = 1'b1;
						if (!found_s1) begin
							mode_d = MODE_REACHED_END;
						end else begin
							take_pd = 1'b1;
						end
					end
					MODE_FORCED_STOP, MODE_REACHED_END: begin
						upd_d = 1'b1;
					end
					default: ;
				endcase
			end
			ACT_START: begin
				if (mode_q != MODE_INIT && mode_q != MODE_CALIBRATING) begin
					mode_d = MODE_FOLLOWING;
				end
			end
			ACT_STOP: begin
				upd_d = 1'b1;
				if (mode_q != MODE_CALIBRATING && mode_q != MODE_REACHED_END) begin
					mode_d = MODE_FORCED_STOP;
				end
			end
			ACT_CALIBRATE: begin
				if (mode_q == MODE_INIT || mode_q == MODE_REACHED_END) begin
					mode_d = MODE_CALIBRATING;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			update_s2 <= upd_d;
			left_s2   <= take_pd ? pd_left : '0;
			right_s2  <= take_pd ? pd_right : '0;
			pulse_s2  <= pulse_d;
			mode_s2   <= mode_d;
		end
	end

	assign result_valid    = valid_s2;
	assign motor_update    = update_s2;
	assign left_speed      = left_s2;
	assign right_speed     = right_s2;
	assign calibrate_pulse = pulse_s2;
	assign mode            = mode_s2;

	`PDLF_ASSERT(a_pulse_only_to_ready, !(valid_s2 && pulse_s2)
		|| (mode_s2 == MODE_READY && !update_s2), "calibrate pulse without move to ready")
	`PDLF_ASSERT(a_idle_speeds_zero, !valid_s2 || update_s2
		|| (left_s2 == '0 && right_s2 == '0), "nonzero speed without motor update")
	`PDLF_ASSERT_NEXT(a_s1_holds, valid_s1 && !s2_free, valid_s1 && valid_s2,
		"stalled request lost")

endmodule

// File: bench/pd_line_follow_steering_tb.sv
// ----------------------------------------------------------------------------
// pd_line_follow_steering_tb
// Self-checking bench for the PD line follower steering controller. Requests
// are driven with random gaps and random result back-pressure. Each one runs
// through a local model of the mode sequencer and PD speed update. Every result
// is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pd_line_follow_steering_tb import pdlf_pkg::*; ();

	localparam int GAIN_SCALE     = 256;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic                      motor_update;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic                      calibrate_pulse;
		mode_t                     next_mode;
	} steer_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      item_valid;
	logic                      item_stall;
	logic [1:0]                action;
	logic                      line_found;
	logic [POS_W-1:0]          line_position;
	logic                      result_valid;
	logic                      result_stall;
	logic                      motor_update;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic                      calibrate_pulse;
	logic [2:0]                mode;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	// Local copy of the controller state and its registers.
	mode_t                   ctl_mode;
	logic signed [ERR_W-1:0] ctl_prev_error;
	pdlf_cfg_t               ctl_cfg;

	steer_result_t expected_steering_q[$];

	int send_idle_pct;
	int recv_stall_pct;
	int requests_sent;
	int results_checked;
	int config_writes;
	int mismatch_count;
	int quiet_cycles;

	pd_line_follow_steering dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.action          (action),
		.line_found      (line_found),
		.line_position   (line_position),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.motor_update    (motor_update),
		.left_speed      (left_speed),
		.right_speed     (right_speed),
		.calibrate_pulse (calibrate_pulse),
		.mode            (mode),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [SPEED_W-1:0] clamp_speed(int speed);
		int lower;
		int upper;
		lower = ctl_cfg.floor_spd;
		upper = ctl_cfg.ceil_spd;
		// The lower bound is checked first, so with it above the upper bound
		// the result is one bound or the other.
		if (speed < lower)
			return ctl_cfg.floor_spd;
		if (speed > upper)
			return upper[SPEED_W-1:0];
		return speed[SPEED_W-1:0];
	endfunction

	function automatic steer_result_t predict_steering(action_t act, logic found,
			logic [POS_W-1:0] pos);
		steer_result_t res;
		int position;
		int error_now;
		int steer;
		res.motor_update    = 1'b0;
		res.left_speed      = '0;
		res.right_speed     = '0;
		res.calibrate_pulse = 1'b0;
		position = (pos > POS_MAX) ? int'(POS_MAX) : int'(pos);
		case (act)
			ACT_TICK: begin
				case (ctl_mode)
					MODE_CALIBRATING: begin
						res.calibrate_pulse = 1'b1;
						ctl_mode = MODE_READY;
					end
					MODE_FOLLOWING: begin
						res.motor_update = 1'b1;
						if (!found) begin
							ctl_mode = MODE_REACHED_END;
						end else begin
							// Integer division by the gain scale truncates toward zero.
							error_now = position - int'(POS_CENTER);
							steer = (error_now * int'(ctl_cfg.prop_gain)) / GAIN_SCALE
								+ ((error_now - int'(ctl_prev_error))
								* int'(ctl_cfg.deriv_gain)) / GAIN_SCALE;
							ctl_prev_error = error_now[ERR_W-1:0];
							res.left_speed  = clamp_speed(int'(ctl_cfg.cruise_spd) + steer);
							res.right_speed = clamp_speed(int'(ctl_cfg.cruise_spd) - steer);
						end
					end
					MODE_FORCED_STOP, MODE_REACHED_END: begin
						res.motor_update = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ACT_START: begin
				if (ctl_mode != MODE_INIT && ctl_mode != MODE_CALIBRATING)
					ctl_mode = MODE_FOLLOWING;
			end
			ACT_STOP: begin
				res.motor_update = 1'b1;
				if (ctl_mode != MODE_CALIBRATING && ctl_mode != MODE_REACHED_END)
					ctl_mode = MODE_FORCED_STOP;
			end
			default: begin
				if (ctl_mode == MODE_INIT || ctl_mode == MODE_REACHED_END)
					ctl_mode = MODE_CALIBRATING;
			end
		endcase
		res.next_mode = ctl_mode;
		return res;
	endfunction

	function automatic int pick_setting(int lo, int hi);
		int choice;
		choice = $urandom_range(3);
		if (choice == 0)
			return lo;
		if (choice == 1)
			return hi;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic logic [POS_W-1:0] random_position();
		int choice;
		choice = $urandom_range(9);
		if (choice < 7)
			return POS_W'($urandom_range(4000));
		if (choice < 9)
			return POS_W'($urandom_range(2050, 1950));
		return POS_W'($urandom_range(4095, 4001));
	endfunction

	task automatic send_request(input action_t act, input logic found,
			input logic [POS_W-1:0] pos);
		steer_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid    <= 1'b1;
		action        <= act;
		line_found    <= found;
		line_position <= pos;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		res = predict_steering(act, found, pos);
		expected_steering_q.push_back(res);
		requests_sent++;
	endtask

	// Drops the request valid and waits until every expected result is back.
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_steering_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_PROP_GAIN:  ctl_cfg.prop_gain  = value[GAIN_W-1:0];
			CFG_DERIV_GAIN: ctl_cfg.deriv_gain = value[GAIN_W-1:0];
			CFG_CRUISE_SPD: ctl_cfg.cruise_spd = value[BASE_W-1:0];
			CFG_FLOOR_SPD:  ctl_cfg.floor_spd  = value[SPEED_W-1:0];
			CFG_CEIL_SPD:   ctl_cfg.ceil_spd   = value[BASE_W-1:0];
			default: begin
			end
		endcase
		config_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_controller(input int kp, input int kd, input int base,
			input int min_spd, input int max_spd);
		wait_idle();
		set_register(CFG_PROP_GAIN, kp);
		set_register(CFG_DERIV_GAIN, kd);
		set_register(CFG_CRUISE_SPD, base);
		set_register(CFG_FLOOR_SPD, min_spd);
		set_register(CFG_CEIL_SPD, max_spd);
	endtask

	// From any reachable mode, calibrate, tick and start end in following.
	task automatic enter_following();
		send_request(ACT_CALIBRATE, 1'b0, POS_CENTER);
		send_request(ACT_TICK, 1'b1, POS_CENTER);
		send_request(ACT_START, 1'b0, POS_CENTER);
	endtask

	task automatic test_mode_sequencing();
		send_request(ACT_TICK, 1'b1, 12'd0);
		send_request(ACT_START, 1'b1, 12'd4095);
		send_request(ACT_CALIBRATE, 1'b0, 12'd0);
		send_request(ACT_START, 1'b0, 12'd0);
		send_request(ACT_STOP, 1'b0, 12'd0);
		send_request(ACT_CALIBRATE, 1'b0, 12'd0);
		send_request(ACT_TICK, 1'b0, 12'd0);
		send_request(ACT_TICK, 1'b1, 12'd1000);
		send_request(ACT_CALIBRATE, 1'b0, 12'd0);
		send_request(ACT_START, 1'b0, 12'd0);
		send_request(ACT_TICK, 1'b1, 12'd0);
		send_request(ACT_TICK, 1'b1, 12'd4000);
		send_request(ACT_TICK, 1'b1, 12'd4095);
		send_request(ACT_TICK, 1'b1, 12'd4001);
		send_request(ACT_TICK, 1'b1, POS_CENTER);
		send_request(ACT_START, 1'b1, 12'd3000);
		send_request(ACT_CALIBRATE, 1'b1, 12'd3000);
		send_request(ACT_STOP, 1'b1, 12'd3000);
		send_request(ACT_TICK, 1'b1, 12'd3000);
		send_request(ACT_CALIBRATE, 1'b0, 12'd0);
		send_request(ACT_START, 1'b0, 12'd0);
		send_request(ACT_TICK, 1'b0, 12'd2500);
		send_request(ACT_TICK, 1'b1, 12'd2500);
		send_request(ACT_STOP, 1'b0, 12'd0);
		send_request(ACT_START, 1'b0, 12'd0);
	endtask

	task automatic test_speed_clamps();
		// Largest gains drive the speeds hard into both bounds.
		program_controller(4095, 4095, 400, -400, 400);
		enter_following();
		send_request(ACT_TICK, 1'b1, 12'd0);
		send_request(ACT_TICK, 1'b1, 12'd4000);
		send_request(ACT_TICK, 1'b1, 12'd0);
		send_request(ACT_TICK, 1'b1, 12'd4095);
		send_request(ACT_TICK, 1'b1, 12'd1990);
		// Lower bound above upper bound.
		program_controller(4095, 0, 0, 400, 0);
		enter_following();
		send_request(ACT_TICK, 1'b1, 12'd0);
		send_request(ACT_TICK, 1'b1, 12'd4000);
		send_request(ACT_TICK, 1'b1, POS_CENTER);
		program_controller(0, 0, 400, 300, 100);
		enter_following();
		send_request(ACT_TICK, 1'b1, 12'd100);
		program_controller(0, 0, 0, 300, 100);
		enter_following();
		send_request(ACT_TICK, 1'b1, 12'd3900);
		program_controller(0, 4095, 200, -400, 0);
		enter_following();
		send_request(ACT_TICK, 1'b1, 12'd2001);
		send_request(ACT_TICK, 1'b1, 12'd1999);
	endtask

	task automatic send_random_request();
		int choice;
		choice = $urandom_range(99);
		if (choice < 70)
			send_request(ACT_TICK, 1'b1, random_position());
		else if (choice < 76)
			send_request(ACT_TICK, 1'b0, random_position());
		else if (choice < 84)
			send_request(ACT_START, 1'($urandom_range(1)), random_position());
		else if (choice < 89)
			send_request(ACT_STOP, 1'($urandom_range(1)), random_position());
		else if (choice < 93)
			send_request(ACT_CALIBRATE, 1'($urandom_range(1)), random_position());
		else
			send_request(action_t'($urandom_range(3)), 1'($urandom_range(1)),
				POS_W'($urandom_range(4095)));
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 82;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 82;
				end
				default: begin
					send_idle_pct  = 17;
					recv_stall_pct = 17;
				end
			endcase
			for (int chunk = 0; chunk < 3; chunk++) begin
				program_controller(pick_setting(0, 4095), pick_setting(0, 4095),
					pick_setting(0, 400), pick_setting(-400, 400), pick_setting(0, 400));
				enter_following();
				repeat (68) send_random_request();
			end
		end
	endtask

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		steer_result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_steering_q.size() == 0) begin
				$error("result with no request outstanding: mode %0d", mode);
				mismatch_count++;
			end else begin
				exp_res = expected_steering_q.pop_front();
				results_checked++;
				if (motor_update !== exp_res.motor_update) begin
					$error("motor_update: expected %0d, got %0d",
						exp_res.motor_update, motor_update);
					mismatch_count++;
				end
				if (left_speed !== exp_res.left_speed) begin
					$error("left_speed: expected %0d, got %0d", exp_res.left_speed, left_speed);
					mismatch_count++;
				end
				if (right_speed !== exp_res.right_speed) begin
					$error("right_speed: expected %0d, got %0d",
						exp_res.right_speed, right_speed);
					mismatch_count++;
				end
				if (calibrate_pulse !== exp_res.calibrate_pulse) begin
					$error("calibrate_pulse: expected %0d, got %0d",
						exp_res.calibrate_pulse, calibrate_pulse);
					mismatch_count++;
				end
				if (mode !== exp_res.next_mode) begin
					$error("mode: expected %0d, got %0d", exp_res.next_mode, mode);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run when no channel has moved anything for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake in %0d cycles, %0d results pending",
					WATCHDOG_LIMIT, expected_steering_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		action         = '0;
		line_found     = 1'b0;
		line_position  = '0;
		result_stall   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		ctl_mode       = MODE_INIT;
		ctl_prev_error = '0;
		ctl_cfg.prop_gain  = RST_PROP_GAIN;
		ctl_cfg.deriv_gain = RST_DERIV_GAIN;
		ctl_cfg.cruise_spd = RST_CRUISE_SPD;
		ctl_cfg.floor_spd  = RST_FLOOR_SPD;
		ctl_cfg.ceil_spd   = RST_CEIL_SPD;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_mode_sequencing();
		test_speed_clamps();
		test_random_traffic();
		wait_idle();

		$display("Covered %0d requests: mode walk, clamp corners and random PD traffic.",
			requests_sent);
		$display("Checked %0d results over %0d register writes and four pacing mixes.",
			results_checked, config_writes);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
